// ===== rtl/osq_pkg.sv =====
// ----------------------------------------------------------------------------
// osq_pkg: shared constants and types of the ordered sequence store
// Sizes, request and status codes, and the request and response records
// passed between the stream wrapper and the sequencing core.
// ----------------------------------------------------------------------------
package osq_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int ACT_W  = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 7;
    localparam int DEL_W  = 7;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int IN_TDATA_W   = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int IN_TUSER_W   = ACT_W;
    localparam int OUT_TDATA_W  = ((LEN_W + 1 + VAL_W + VAL_W + DEL_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = STAT_W;

    localparam logic [ACT_W-1:0] ACT_ADD_FRONT  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD_BACK   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ADD_AT     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TAKE_FRONT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TAKE_BACK  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DELETE     = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [LEN_W-1:0]        length;
        logic                    is_empty;
        logic signed [VAL_W-1:0] first_value;
        logic signed [VAL_W-1:0] last_value;
        logic [DEL_W-1:0]        deleted_count;
    } t_rsp;

endpackage

// ===== rtl/osq_core.sv =====
// ----------------------------------------------------------------------------
// osq_core: sequencer and entry memory of the ordered sequence store
// Moves entries one per cycle through a single read and write port to
// insert, remove or compact, then reads the front and back entries.
// ----------------------------------------------------------------------------
module osq_core
    import osq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_idle,
    output logic o_done,
    input  logic i_ack,
    output t_rsp o_rsp
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SHIFT    = 7'b0000010,
        S_DRAIN    = 7'b0000100,
        S_PUT      = 7'b0001000,
        S_RD_FIRST = 7'b0010000,
        S_RD_LAST  = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    logic [VAL_W-1:0] mem [CAPACITY];

    t_state            r_state, n_state;
    logic [ACT_W-1:0]  r_act, n_act;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [IDX_W-1:0]  r_at, n_at;
    logic [IDX_W-1:0]  r_ptr, n_ptr;
    logic [IDX_W-1:0]  r_end, n_end;
    logic [IDX_W-1:0]  r_pwa, n_pwa;
    logic              r_pend, n_pend;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_wr, n_wr;
    logic [CNT_W-1:0]  r_gone, n_gone;
    logic [STAT_W-1:0] r_status, n_status;
    logic [VAL_W-1:0]  r_first, n_first;
    logic [VAL_W-1:0]  r_q;

    logic             re, we;
    logic [IDX_W-1:0] raddr, waddr;
    logic [VAL_W-1:0] wdata;
    logic [CMP_W-1:0] v_at;
    logic [CNT_W-1:0] v_cnt_m1;
    logic             is_ins, is_del;

    assign v_cnt_m1 = r_cnt - CNT_W'(1);
    assign is_del   = (r_act == ACT_DELETE);
    assign is_ins   = (r_act == ACT_ADD_FRONT) || (r_act == ACT_ADD_BACK)
                   || (r_act == ACT_ADD_AT);

    always_comb begin
        unique case (i_req.action)
            ACT_ADD_BACK: v_at = CMP_W'(r_cnt);
            ACT_ADD_AT:   v_at = CMP_W'(i_req.position);
            default:      v_at = '0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_act    = r_act;
        n_val    = r_val;
        n_at     = r_at;
        n_ptr    = r_ptr;
        n_end    = r_end;
        n_pwa    = r_pwa;
        n_pend   = r_pend;
        n_cnt    = r_cnt;
        n_wr     = r_wr;
        n_gone   = r_gone;
        n_status = r_status;
        n_first  = r_first;
        re       = 1'b0;
        raddr    = '0;
        we       = 1'b0;
        waddr    = '0;
        wdata    = r_q;

        if (r_pend) begin
            if (is_del) begin
                if (r_q != r_val) begin
                    we    = 1'b1;
                    waddr = r_wr[IDX_W-1:0];
                    n_wr  = r_wr + CNT_W'(1);
                end else begin
                    n_gone = r_gone + CNT_W'(1);
                end
            end else begin
                we    = 1'b1;
                waddr = r_pwa;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_act    = i_req.action;
                    n_val    = i_req.item_value;
                    n_at     = v_at[IDX_W-1:0];
                    n_pend   = 1'b0;
                    n_wr     = '0;
                    n_gone   = '0;
                    n_status = STAT_OK;
                    n_state  = S_RD_FIRST;
                    unique case (i_req.action)
                        ACT_ADD_FRONT, ACT_ADD_BACK, ACT_ADD_AT: begin
                            if (v_at > CMP_W'(r_cnt)) begin
                                n_status = STAT_BAD_POS;
                            end else if (r_cnt >= CNT_W'(CAPACITY)) begin
                                n_status = STAT_FULL;
                            end else if (v_at == CMP_W'(r_cnt)) begin
                                n_state = S_PUT;
                            end else begin
                                n_ptr   = v_cnt_m1[IDX_W-1:0];
                                n_end   = v_at[IDX_W-1:0];
                                n_state = S_SHIFT;
                            end
                        end
                        ACT_TAKE_FRONT: begin
                            if (r_cnt == '0) begin
                                n_status = STAT_EMPTY;
                            end else if (r_cnt == CNT_W'(1)) begin
                                n_cnt = '0;
                            end else begin
                                n_ptr   = IDX_W'(1);
                                n_end   = v_cnt_m1[IDX_W-1:0];
                                n_state = S_SHIFT;
                            end
                        end
                        ACT_TAKE_BACK: begin
                            if (r_cnt == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_cnt = v_cnt_m1;
                            end
                        end
                        ACT_DELETE: begin
                            if (r_cnt != '0) begin
                                n_ptr   = '0;
                                n_end   = v_cnt_m1[IDX_W-1:0];
                                n_state = S_SHIFT;
                            end
                        end
                        default: begin
                            n_status = STAT_OK;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                re     = 1'b1;
                raddr  = r_ptr;
                n_pend = 1'b1;
                n_pwa  = is_ins ? (r_ptr + IDX_W'(1)) : (r_ptr - IDX_W'(1));
                if (r_ptr == r_end) begin
                    n_state = S_DRAIN;
                end else begin
                    n_ptr = is_ins ? (r_ptr - IDX_W'(1)) : (r_ptr + IDX_W'(1));
                end
            end
            S_DRAIN: begin
                n_pend = 1'b0;
                if (is_ins) begin
                    n_state = S_PUT;
                end else if (is_del) begin
                    n_cnt   = n_wr;
                    n_state = S_RD_FIRST;
                end else begin
                    n_cnt   = v_cnt_m1;
                    n_state = S_RD_FIRST;
                end
            end
            S_PUT: begin
                we      = 1'b1;
                waddr   = r_at;
                wdata   = r_val;
                n_cnt   = r_cnt + CNT_W'(1);
                n_state = S_RD_FIRST;
            end
            S_RD_FIRST: begin
                re      = 1'b1;
                raddr   = '0;
                n_state = S_RD_LAST;
            end
            S_RD_LAST: begin
                re      = 1'b1;
                raddr   = v_cnt_m1[IDX_W-1:0];
                n_first = r_q;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (re) begin
            r_q <= mem[raddr];
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_val    <= n_val;
        r_at     <= n_at;
        r_ptr    <= n_ptr;
        r_end    <= n_end;
        r_pwa    <= n_pwa;
        r_wr     <= n_wr;
        r_gone   <= n_gone;
        r_status <= n_status;
        r_first  <= n_first;
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);

    always_comb begin
        o_rsp.status        = r_status;
        o_rsp.length        = LEN_W'(r_cnt);
        o_rsp.is_empty      = (r_cnt == '0);
        o_rsp.first_value   = (r_cnt == '0) ? '0 : r_first;
        o_rsp.last_value    = (r_cnt == '0) ? '0 : r_q;
        o_rsp.deleted_count = DEL_W'(r_gone);
    end

endmodule

// ===== rtl/ordered_sequence_store.sv =====
// ----------------------------------------------------------------------------
// ordered_sequence_store: bounded double-ended sequence of signed words
// A beat is registered, then the core reads the front and back entries, and the result
// loads into the output register once that register is empty or being read. An append
// first writes the item; take-front and delete first move or scan the entries, and an
// insert moves entries, then writes the item. The next beat is accepted in the cycle
// after the result loads. Reset empties the store.
module ordered_sequence_store
    import osq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // position, item_value, zero fill.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action.
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // length, is_empty, first_value, last_value, deleted_count, zero fill.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status.
    output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    t_req req;
    t_rsp rsp;
    logic core_idle, core_done, core_ack, start;

    logic                   r_ov, n_ov;
    logic [OUT_TDATA_W-1:0] r_odata, n_odata;
    logic [OUT_TUSER_W-1:0] r_ouser, n_ouser;

    assign req.action     = s_axis_tuser[ACT_W-1:0];
    assign req.position   = s_axis_tdata[POS_W-1:0];
    assign req.item_value = s_axis_tdata[POS_W +: VAL_W];

    assign s_axis_tready = core_idle;
    assign start         = s_axis_tvalid && core_idle;
    assign core_ack      = core_done && (!r_ov || m_axis_tready);

    osq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (req),
        .o_idle  (core_idle),
        .o_done  (core_done),
        .i_ack   (core_ack),
        .o_rsp   (rsp)
    );

    always_comb begin
        n_ov    = r_ov;
        n_odata = r_odata;
        n_ouser = r_ouser;
        if (core_ack) begin
            n_ov    = 1'b1;
            n_ouser = OUT_TUSER_W'(rsp.status);
            n_odata = OUT_TDATA_W'({rsp.deleted_count, rsp.last_value, rsp.first_value,
                                    rsp.is_empty, rsp.length});
        end else if (m_axis_tready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
        r_ouser <= n_ouser;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule
